// ===== rtl/oais_pkg.sv =====
package oais_pkg;

  localparam int CAPACITY  = 16;
  localparam int WORD_BITS = 32;

  // widths of the port fields
  localparam int POS_W  = 5;
  localparam int ELEM_W = 32;
  localparam int FIDX_W = 4;

  // internal widths that follow from the capacity
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int PW    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [ELEM_W-1:0]    elem_t;

  typedef enum logic [2:0] {
    KIND_INSERT    = 3'd0,
    KIND_REM_FRONT = 3'd1,
    KIND_REM_AT    = 3'd2,
    KIND_SEARCH    = 3'd3,
    KIND_READ      = 3'd4,
    KIND_CREATE    = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_RANGE = 3'd1,
    ST_EMPTY = 3'd2,
    ST_MISS  = 3'd3,
    ST_FULL  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE,
    OP_CLEAR
  } cell_op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_e;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_op_e         op;
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] count;
    word_t            value;
  } cell_cmd_t;

  typedef struct packed {
    logic [2:0]       kind;
    elem_t            value;
    logic [POS_W-1:0] position;
  } in_t;

  typedef struct packed {
    logic [2:0]        status;
    elem_t             element;
    logic [FIDX_W-1:0] found_index;
    logic [POS_W-1:0]  count;
  } out_t;

  // input value kept in WORD_BITS bits
  function automatic word_t to_word(input elem_t v);
    return word_t'(v);
  endfunction

  // stored word sign-extended (or cut) to the port width
  function automatic elem_t widen(input word_t w);
    return elem_t'(w);
  endfunction

endpackage

// ===== rtl/oais_cell.sv =====
module oais_cell (
  input  logic                       clk_i,
  input  logic [oais_pkg::CNT_W-1:0] idx_i,
  input  oais_pkg::cell_cmd_t        cmd_i,
  input  oais_pkg::word_t            lower_i,
  input  oais_pkg::word_t            upper_i,
  output oais_pkg::word_t            entry_o,
  output logic                       match_o
);
  import oais_pkg::*;

  word_t entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    unique case (cmd_i.op)
      OP_INSERT: begin
        if (idx_i == cmd_i.pos) begin
          entry_d = cmd_i.value;
        end else if (idx_i > cmd_i.pos && idx_i <= cmd_i.count) begin
          entry_d = lower_i;
        end
      end
      OP_REMOVE: begin
        // tail moves down one place; last used slot keeps its stale word
        if (idx_i >= cmd_i.pos && (CNT_W'(idx_i + 1'b1) < cmd_i.count)) begin
          entry_d = upper_i;
        end
      end
      OP_CLEAR: begin
        if (idx_i < cmd_i.pos) begin
          entry_d = '0;
        end
      end
      OP_HOLD: begin
        entry_d = entry_q;
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign match_o = (entry_q == cmd_i.value) && (idx_i < cmd_i.count);

endmodule

// ===== rtl/ordered_array_insert_remove_search_top.sv =====
// Positional list of up to CAPACITY signed words held in a chain of cells,
// one entry per cell. A request is taken when start_i is high and busy_o is
// low; busy_o is high for one cycle while the chain shifts, clears or
// compares all entries at once, and the result appears on rsp_o with
// valid_o high in the following cycle. A new request may be issued in the
// cycle the result is shown, but none is taken while busy_o is high. The
// result is strobed for a single cycle and must be captured then; there is
// no way to hold it.
module ordered_array_insert_remove_search_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  oais_pkg::in_t  req_i,
  output logic           busy_o,
  output logic           valid_o,
  output oais_pkg::out_t rsp_o
);
  import oais_pkg::*;

  typedef struct packed {
    status_e          status;
    elem_t            elem;
    logic             search;
    logic [CNT_W-1:0] count;
  } exec_rsp_t;

  state_e           state_q, state_d;
  in_t              req_q;
  logic [CNT_W-1:0] count_q, count_d;
  exec_rsp_t        rsp_q, rsp_d;
  logic [CAPACITY-1:0] match_q, match;

  cell_cmd_t        cmd;
  word_t            ent [CAPACITY];
  word_t            req_word;
  logic [PW-1:0]    pos_ext, cnt_ext;
  logic [IDX_W-1:0] rd_idx;
  logic             accept;

  assign accept   = start_i && !busy_o;
  assign req_word = to_word(req_q.value);
  assign pos_ext  = PW'(req_q.position);
  assign cnt_ext  = PW'(count_q);

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    word_t lower, upper;
    if (i == 0) begin : g_first
      assign lower = cmd.value;
    end else begin : g_mid_lo
      assign lower = ent[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign upper = '0;
    end else begin : g_mid_hi
      assign upper = ent[i+1];
    end
    oais_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (CNT_W'(i)),
      .cmd_i   (cmd),
      .lower_i (lower),
      .upper_i (upper),
      .entry_o (ent[i]),
      .match_o (match[i])
    );
  end

  // state machine
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  state_d = start_i ? S_EXEC : S_IDLE;
      S_EXEC:  state_d = S_RESP;
      S_RESP:  state_d = start_i ? S_EXEC : S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o  = (state_q == S_EXEC);
  assign valid_o = (state_q == S_RESP);

  // request decode during the execute cycle
  always_comb begin
    cmd.op      = OP_HOLD;
    cmd.pos     = CNT_W'(pos_ext);
    cmd.count   = count_q;
    cmd.value   = req_word;
    rd_idx      = IDX_W'(pos_ext);
    count_d     = count_q;
    rsp_d.status = ST_OK;
    rsp_d.elem   = '0;
    rsp_d.search = 1'b0;
    if (state_q == S_EXEC) begin
      unique case (req_q.kind)
        KIND_INSERT: begin
          if (pos_ext > cnt_ext) begin
            rsp_d.status = ST_RANGE;
          end else if (cnt_ext >= PW'(CAPACITY)) begin
            rsp_d.status = ST_FULL;
          end else begin
            cmd.op  = OP_INSERT;
            count_d = count_q + 1'b1;
          end
        end
        KIND_REM_FRONT: begin
          if (count_q == '0) begin
            rsp_d.status = ST_EMPTY;
          end else begin
            rd_idx     = '0;
            cmd.op     = OP_REMOVE;
            cmd.pos    = '0;
            rsp_d.elem = widen(ent[rd_idx]);
            count_d    = count_q - 1'b1;
          end
        end
        KIND_REM_AT: begin
          if (pos_ext >= cnt_ext) begin
            rsp_d.status = ST_RANGE;
          end else begin
            cmd.op     = OP_REMOVE;
            rsp_d.elem = widen(ent[rd_idx]);
            count_d    = count_q - 1'b1;
          end
        end
        KIND_SEARCH: begin
          // a hit returns the searched word itself
          rsp_d.search = 1'b1;
          rsp_d.elem   = widen(req_word);
        end
        KIND_READ: begin
          if (pos_ext >= cnt_ext) begin
            rsp_d.status = ST_RANGE;
          end else begin
            rsp_d.elem = widen(ent[rd_idx]);
          end
        end
        KIND_CREATE: begin
          if (pos_ext > PW'(CAPACITY)) begin
            rsp_d.status = ST_RANGE;
          end else begin
            cmd.op  = OP_CLEAR;
            count_d = CNT_W'(pos_ext);
          end
        end
        default: begin
          rsp_d.status = ST_OK;
        end
      endcase
    end
    rsp_d.count = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_EXEC) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    if (state_q == S_EXEC) begin
      rsp_q   <= rsp_d;
      match_q <= match;
    end
  end

  // first match: isolate the lowest set bit, then encode it
  logic [CAPACITY-1:0] first;
  logic [IDX_W-1:0]    hit_idx;
  logic                any_hit;

  assign first   = match_q & (~match_q + 1'b1);
  assign any_hit = |match_q;

  always_comb begin
    hit_idx = '0;
    for (int b = 0; b < IDX_W; b++) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (((i >> b) & 1) == 1) begin
          hit_idx[b] = hit_idx[b] | first[i];
        end
      end
    end
  end

  always_comb begin
    rsp_o.status      = rsp_q.status;
    rsp_o.element     = rsp_q.elem;
    rsp_o.found_index = '0;
    rsp_o.count       = POS_W'(rsp_q.count);
    if (rsp_q.search) begin
      if (any_hit) begin
        rsp_o.status      = ST_OK;
        rsp_o.found_index = FIDX_W'(hit_idx);
      end else begin
        rsp_o.status  = ST_MISS;
        rsp_o.element = '0;
      end
    end
  end

  a_exec_then_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> valid_o)
    else $error("execute cycle not followed by result");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted transaction did not enter execute");

  a_count_only_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> $past(busy_o))
    else $error("count changed outside execute cycle");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("count above capacity");

  a_hit_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $onehot0(first))
    else $error("first-match vector not one-hot");

endmodule
